### hw/rtl/scd_pkg.sv
// Shared constants and types for the sync/length/checksum deframer.
`timescale 1ns / 1ps

package scd_pkg;

	// Frame layout constants
	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] ID_MIN = 8'h01;
	localparam logic [7:0] ID_MAX = 8'h04;

	// Payload bytes at this index or beyond are flagged as overflow
	localparam logic [15:0] MAX_PAYLOAD = 16'd128;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOF = 1'b1;

	// One result item
	typedef struct packed {
		logic        kind;
		logic [2:0]  device;
		logic [7:0]  byte_value;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic        frame_good;
		logic        overflow;
	} res_t;

	// Parser view of the byte it currently holds
	typedef struct packed {
		logic emit;
		res_t res;
	} parse_out_t;

endpackage

### hw/rtl/scd_if.sv
// Valid/ready channel interfaces for received bytes and parsed results.
`timescale 1ns / 1ps

interface scd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface scd_tx_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [2:0]  device;
	logic [7:0]  byte_value;
	logic [15:0] byte_index;
	logic [15:0] frame_length;
	logic        frame_good;
	logic        overflow;

	modport source(output valid, output kind, output device, output byte_value,
		output byte_index, output frame_length, output frame_good, output overflow,
		input ready);
	modport sink(input valid, input kind, input device, input byte_value,
		input byte_index, input frame_length, input frame_good, input overflow,
		output ready);
endinterface

### hw/rtl/sync_length_checksum_deframer.sv
// Top level of the byte-serial frame deframer with mod-255 check byte.
`timescale 1ns / 1ps

// Takes one received byte per item and hunts for frames FF FF, id (1 to 4),
// 16-bit big-endian length, payload, check byte. Every payload byte comes out
// as a result with its index and an overflow flag (index at or past
// MAX_PAYLOAD); the check byte comes out as an end-of-frame result whose
// frame_good is set when the byte equals the 16-bit sum of id, length and
// payload modulo 255 and no byte overflowed. Header and sync bytes give no
// result. The block sustains one byte per cycle while results are taken:
// a byte is held in the input register, the parse state updates once per
// byte, and a result shows in the output register in the cycle after its
// byte is consumed. The parse state update (phase, running sum, byte count)
// sets that rate. A byte with no result moves on even while a result waits.
module sync_length_checksum_deframer (
	input  logic     clk,
	input  logic     arst_n,
	scd_rx_if.sink   rx,
	scd_tx_if.source tx
);
	import scd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       adv;
	logic       load;
	parse_out_t po;

	// Advance a held byte when it needs no result slot or the slot frees up
	assign out_free = !tx.valid || tx.ready;
	assign adv      = valid_s1 && (!po.emit || out_free);
	assign load     = adv && po.emit;
	assign rx.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	scd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.po      (po)
	);

	scd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res    (po.res),
		.tx     (tx)
	);

	// A pending result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!tx.valid || tx.ready))
		else $error("result register loaded while a result was pending");

	// A held byte stays put until the parser consumes it
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte was lost or changed");

	// A good verdict never comes with overflow
	a_good_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.kind == KIND_EOF && tx.frame_good) |-> !tx.overflow)
		else $error("frame marked good despite overflow");

	// Payload results never carry a good flag
	a_data_not_good: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.kind == KIND_DATA) |-> !tx.frame_good)
		else $error("payload result carries frame_good");

endmodule

### hw/rtl/scd_parser.sv
// Frame parser: phase state, running sum, counters and result formation.
`timescale 1ns / 1ps

module scd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	output scd_pkg::parse_out_t po
);
	import scd_pkg::*;

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_ID    = 3'd2,
		PH_LEN1  = 3'd3,
		PH_LEN2  = 3'd4,
		PH_DATA  = 3'd5,
		PH_CHECK = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] sum_q, sum_d;
	logic [2:0]  dev_q, dev_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic        ovf_seen_q, ovf_seen_d;

	logic [15:0] sum_add;
	logic [8:0]  fold9;
	logic [7:0]  fold8;
	logic [7:0]  chk;
	logic        ovf_now;

	// Running sum plus the current byte, and the sum folded modulo 255
	assign sum_add = sum_q + {8'h00, rx_byte};
	assign fold9   = {1'b0, sum_q[15:8]} + {1'b0, sum_q[7:0]};
	assign fold8   = fold9[7:0] + {7'b0, fold9[8]};
	assign chk     = (fold8 == 8'hFF) ? 8'h00 : fold8;
	assign ovf_now = (count_q >= MAX_PAYLOAD);

	// Next state and result for the byte at hand
	always_comb begin
		phase_d    = phase_q;
		sum_d      = sum_q;
		dev_d      = dev_q;
		len_hi_d   = len_hi_q;
		len_d      = len_q;
		count_d    = count_q;
		ovf_seen_d = ovf_seen_q;

		po.emit             = (phase_q == PH_DATA) || (phase_q == PH_CHECK);
		po.res.kind         = KIND_DATA;
		po.res.device       = dev_q;
		po.res.byte_value   = rx_byte;
		po.res.byte_index   = count_q;
		po.res.frame_length = len_q;
		po.res.frame_good   = 1'b0;
		po.res.overflow     = ovf_now;

		case (phase_q)
			PH_SYNC2: begin
				phase_d = (rx_byte == SYNC_BYTE) ? PH_ID : PH_SYNC1;
			end
			PH_ID: begin
				if (rx_byte >= ID_MIN && rx_byte <= ID_MAX) begin
					dev_d   = rx_byte[2:0];
					sum_d   = sum_add;
					phase_d = PH_LEN1;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_LEN1: begin
				sum_d    = sum_add;
				len_hi_d = rx_byte;
				phase_d  = PH_LEN2;
			end
			PH_LEN2: begin
				sum_d   = sum_add;
				len_d   = {len_hi_q, rx_byte};
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				sum_d   = sum_add;
				count_d = count_q + 16'd1;
				if (ovf_now) begin
					ovf_seen_d = 1'b1;
				end
				// A zero length still takes one byte, as the count is tested after it
				if (count_d >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				po.res.kind       = KIND_EOF;
				po.res.byte_value = 8'h00;
				po.res.frame_good = (rx_byte == chk) && !ovf_seen_q;
				po.res.overflow   = ovf_seen_q;
				sum_d             = 16'h0000;
				phase_d           = PH_SYNC1;
			end
			default: begin
				// Hunt for the first sync byte; unused codes land here too
				if (rx_byte == SYNC_BYTE) begin
					phase_d    = PH_SYNC2;
					sum_d      = 16'h0000;
					count_d    = 16'h0000;
					ovf_seen_d = 1'b0;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
		endcase
	end

	// Advance the parse state once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC1;
			sum_q      <= 16'h0000;
			dev_q      <= 3'd0;
			len_hi_q   <= 8'h00;
			len_q      <= 16'h0000;
			count_q    <= 16'h0000;
			ovf_seen_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			sum_q      <= sum_d;
			dev_q      <= dev_d;
			len_hi_q   <= len_hi_d;
			len_q      <= len_d;
			count_q    <= count_d;
			ovf_seen_q <= ovf_seen_d;
		end
	end

endmodule

### hw/rtl/scd_out_reg.sv
// Result register that drives the output channel.
`timescale 1ns / 1ps

module scd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  scd_pkg::res_t res,
	scd_tx_if.source      tx
);
	import scd_pkg::*;

	logic valid_q;
	res_t res_q;

	// Hold a result until taken; a load may replace it in the cycle it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign tx.valid        = valid_q;
	assign tx.kind         = res_q.kind;
	assign tx.device       = res_q.device;
	assign tx.byte_value   = res_q.byte_value;
	assign tx.byte_index   = res_q.byte_index;
	assign tx.frame_length = res_q.frame_length;
	assign tx.frame_good   = res_q.frame_good;
	assign tx.overflow     = res_q.overflow;

endmodule
